// ===== rtl/core/ectil_pkg.sv =====
// Shared types and constants for the encoder count tracker.
package ectil_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned POS_W    = 56;
  localparam int unsigned PERIOD_W = 48;
  localparam int unsigned PROD_W   = 2 * WORD_W;
  localparam int unsigned GAIN_SHIFT = 16;
  localparam int unsigned ADDR_W   = 4;

  localparam logic [WORD_W-1:0] SCALE_RESET = 32'd16777216;
  localparam logic [WORD_W-1:0] GAIN_RESET  = 32'd65536;
  localparam logic [WORD_W-1:0] PRESET_RESET = '0;

  // Register word index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_INVERSE_SCALE = 2'd0,
    REG_PERIOD_GAIN   = 2'd1,
    REG_PRESET_VALUE  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] inverse_scale;
    logic        [WORD_W-1:0] period_gain;
    logic signed [WORD_W-1:0] preset_value;
  } cfg_t;

  // Tracker state as seen by the scaling stage.
  typedef struct packed {
    logic signed [WORD_W-1:0] net_count;
    logic signed [WORD_W-1:0] count_hold;
    logic signed [WORD_W-1:0] latch_hold;
    logic        [WORD_W-1:0] period_hold;
    logic                     index_armed;
    logic                     rising_armed;
    logic                     falling_armed;
    logic                     preset_pending;
  } trk_t;

endpackage

// ===== rtl/core/ectil_if.sv =====
// Request and result channel interfaces for the encoder count tracker.
interface ectil_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 link_operational;
  logic signed [ectil_pkg::WORD_W-1:0]  counter_word;
  logic signed [ectil_pkg::WORD_W-1:0]  latch_word;
  logic        [ectil_pkg::WORD_W-1:0]  period_word;
  logic                                 index_latched;
  logic                                 external_latched;
  logic                                 preset_done;
  logic                                 clear_request;
  logic                                 arm_index;
  logic                                 arm_rising;
  logic                                 arm_falling;
  logic                                 preset_request;

  modport source (
    output valid, link_operational, counter_word, latch_word, period_word,
           index_latched, external_latched, preset_done, clear_request,
           arm_index, arm_rising, arm_falling, preset_request,
    input  ready
  );
  modport sink (
    input  valid, link_operational, counter_word, latch_word, period_word,
           index_latched, external_latched, preset_done, clear_request,
           arm_index, arm_rising, arm_falling, preset_request,
    output ready
  );
endinterface

interface ectil_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ectil_pkg::WORD_W-1:0]   net_count;
  logic signed [ectil_pkg::POS_W-1:0]    position;
  logic signed [ectil_pkg::WORD_W-1:0]   held_count;
  logic signed [ectil_pkg::WORD_W-1:0]   held_latch;
  logic        [ectil_pkg::WORD_W-1:0]   held_period;
  logic        [ectil_pkg::PERIOD_W-1:0] scaled_period;
  logic                                  index_enable;
  logic                                  rising_enable;
  logic                                  falling_enable;
  logic                                  preset_command;
  logic signed [ectil_pkg::WORD_W-1:0]   preset_word;

  modport source (
    output valid, net_count, position, held_count, held_latch, held_period,
           scaled_period, index_enable, rising_enable, falling_enable,
           preset_command, preset_word,
    input  ready
  );
  modport sink (
    input  valid, net_count, position, held_count, held_latch, held_period,
           scaled_period, index_enable, rising_enable, falling_enable,
           preset_command, preset_word,
    output ready
  );
endinterface

// ===== rtl/core/encoder_count_tracker_index_latch.sv =====
// Top level of the encoder count tracker with index and external latch handling.
//
// Usage:
//   item   - request channel, one request per bus cycle of the encoder
//            terminal: counter, latch and period words, latch-valid and
//            set-done flags, host clear/arm/preset requests.
//   result - one result per request: net count, saturated fixed-point
//            position, held raw words, scaled period, latch enables,
//            preset command and preset word.
//   APB    - scale, gain and preset registers at byte addresses 0, 4, 8;
//            write them only while no request is in flight.
// Pipeline: an accepted request is registered in the tracker state stage,
//   then in the result register that holds the products (two register stages).
// Throughput: one request per clock while result is taken; the tracker state
//   update and the two 32x32 multiplies each fit in one stage.
// Reset: drops both stages, restores register defaults and clears the
//   tracker state (first pass armed, link considered down).
// Stall: when result is not taken, the result register holds and the
//   tracker stage still takes one more request before item.ready drops.
module encoder_count_tracker_index_latch (
  input  logic                          clk,
  input  logic                          rst,
  ectil_in_if.sink                      item,
  ectil_out_if.source                   result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ectil_pkg::ADDR_W-1:0]  paddr,
  input  logic [ectil_pkg::WORD_W-1:0]  pwdata,
  output logic [ectil_pkg::WORD_W-1:0]  prdata,
  output logic                          pready
);

  ectil_pkg::cfg_t  cfg;
  ectil_pkg::trk_t  trk;
  logic             trk_valid;
  logic             advance;

  // Hold configuration registers.
  ectil_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the tracker state on each accepted request.
  ectil_track u_track (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .advance   (advance),
    .trk_valid (trk_valid),
    .trk       (trk)
  );

  // Scale position and period into the result register.
  ectil_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .trk_valid (trk_valid),
    .trk       (trk),
    .cfg       (cfg),
    .advance   (advance),
    .result    (result)
  );

`ifndef ASSERT_OFF
  // Reset empties both stages.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!trk_valid && !result.valid))
    else $error("pipeline not empty after reset");

  // An index arm request always shows unless an index latch on the same cycle clears it.
  a_arm_index: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.arm_index &&
     !(item.link_operational && item.index_latched)) |=> trk.index_armed)
    else $error("index arm request lost");

  // A clear request without a latch zeroes the net count.
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.link_operational && item.clear_request &&
     !item.external_latched && !item.index_latched)
    |=> (trk.net_count == '0))
    else $error("clear request did not zero net count");

  // A stalled result with a full tracker stage must block new requests.
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (trk_valid && result.valid && !result.ready) |-> !item.ready)
    else $error("request taken while both stages are full");
`endif

endmodule

// ===== rtl/core/ectil_cfg.sv =====
// APB register file holding scale, gain and preset value.
module ectil_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ectil_pkg::ADDR_W-1:0]     paddr,
  input  logic [ectil_pkg::WORD_W-1:0]     pwdata,
  output logic [ectil_pkg::WORD_W-1:0]     prdata,
  output logic                             pready,
  output ectil_pkg::cfg_t                  cfg
);

  logic                  wr_en;
  ectil_pkg::reg_idx_t   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = ectil_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inverse_scale <= ectil_pkg::SCALE_RESET;
      cfg.period_gain   <= ectil_pkg::GAIN_RESET;
      cfg.preset_value  <= ectil_pkg::PRESET_RESET;
    end else if (wr_en) begin
      unique case (idx)
        ectil_pkg::REG_INVERSE_SCALE: cfg.inverse_scale <= pwdata;
        ectil_pkg::REG_PERIOD_GAIN:   cfg.period_gain   <= pwdata;
        ectil_pkg::REG_PRESET_VALUE:  cfg.preset_value  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ectil_pkg::REG_INVERSE_SCALE: prdata = cfg.inverse_scale;
      ectil_pkg::REG_PERIOD_GAIN:   prdata = cfg.period_gain;
      ectil_pkg::REG_PRESET_VALUE:  prdata = cfg.preset_value;
      default:                      prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/ectil_track.sv =====
// Count tracking stage: arming, rebasing, net count and hold registers.
module ectil_track (
  input  logic             clk,
  input  logic             rst,
  ectil_in_if.sink         item,
  input  logic             advance,
  output logic             trk_valid,
  output ectil_pkg::trk_t  trk
);

  logic                                accept;
  logic                                first_pass, first_pass_next;
  logic                                was_operational, was_operational_next;
  logic signed [ectil_pkg::WORD_W-1:0] previous_count, previous_count_next;
  logic signed [ectil_pkg::WORD_W-1:0] base;
  logic                                zero_acc;
  ectil_pkg::trk_t                     trk_next;

  // Take a request whenever the stage is empty or drains this cycle.
  assign item.ready = !trk_valid || advance;
  assign accept     = item.valid && item.ready;

  always_comb begin
    trk_next                = trk;
    first_pass_next         = first_pass;
    was_operational_next    = was_operational;
    previous_count_next     = previous_count;
    base                    = previous_count;
    zero_acc                = 1'b0;

    trk_next.index_armed    = trk.index_armed    | item.arm_index;
    trk_next.rising_armed   = trk.rising_armed   | item.arm_rising;
    trk_next.falling_armed  = trk.falling_armed  | item.arm_falling;
    trk_next.preset_pending = trk.preset_pending | item.preset_request;

    if (!item.link_operational) begin
      was_operational_next = 1'b0;
    end else begin
      if (!was_operational || item.preset_done) begin
        base = item.counter_word;
      end
      if (item.preset_done) begin
        trk_next.preset_pending = 1'b0;
      end
      if (!trk_next.preset_pending) begin
        trk_next.count_hold  = item.counter_word;
        trk_next.period_hold = item.period_word;
      end
      if (first_pass || item.clear_request) begin
        first_pass_next = 1'b0;
        base            = item.counter_word;
        zero_acc        = 1'b1;
      end
      // A valid latch rebases to the latched word.
      if (item.external_latched) begin
        trk_next.latch_hold    = item.latch_word;
        base                   = item.latch_word;
        zero_acc               = 1'b1;
        trk_next.rising_armed  = 1'b0;
        trk_next.falling_armed = 1'b0;
      end
      if (item.index_latched) begin
        trk_next.latch_hold  = item.latch_word;
        base                 = item.latch_word;
        zero_acc             = 1'b1;
        trk_next.index_armed = 1'b0;
      end
      trk_next.net_count   = (zero_acc ? '0 : trk.net_count) + item.counter_word - base;
      previous_count_next  = item.counter_word;
      was_operational_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trk_valid       <= 1'b0;
      trk             <= '0;
      first_pass      <= 1'b1;
      was_operational <= 1'b0;
      previous_count  <= '0;
    end else begin
      if (item.ready) begin
        trk_valid <= item.valid;
      end
      if (accept) begin
        trk             <= trk_next;
        first_pass      <= first_pass_next;
        was_operational <= was_operational_next;
        previous_count  <= previous_count_next;
      end
    end
  end

endmodule

// ===== rtl/core/ectil_scale.sv =====
// Scaling stage: position and period products into the result register.
module ectil_scale (
  input  logic             clk,
  input  logic             rst,
  input  logic             trk_valid,
  input  ectil_pkg::trk_t  trk,
  input  ectil_pkg::cfg_t  cfg,
  output logic             advance,
  ectil_out_if.source      result
);

  logic signed [ectil_pkg::PROD_W-1:0]   pos_prod;
  logic        [ectil_pkg::PROD_W-1:0]   per_prod;
  logic signed [ectil_pkg::POS_W-1:0]    pos_sat;
  logic                                  pos_fits;

  assign advance  = !result.valid || result.ready;

  assign pos_prod = trk.net_count * cfg.inverse_scale;
  assign per_prod = trk.period_hold * cfg.period_gain;

  // Product fits when the sign bit and all bits above it agree.
  assign pos_fits = (pos_prod[ectil_pkg::PROD_W-1:ectil_pkg::POS_W-1] == '0)
                 || (pos_prod[ectil_pkg::PROD_W-1:ectil_pkg::POS_W-1] == '1);

  always_comb begin
    if (pos_fits) begin
      pos_sat = pos_prod[ectil_pkg::POS_W-1:0];
    end else if (pos_prod[ectil_pkg::PROD_W-1]) begin
      pos_sat = {1'b1, {(ectil_pkg::POS_W-1){1'b0}}};
    end else begin
      pos_sat = {1'b0, {(ectil_pkg::POS_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= trk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && trk_valid) begin
      result.net_count      <= trk.net_count;
      result.position       <= pos_sat;
      result.held_count     <= trk.count_hold;
      result.held_latch     <= trk.latch_hold;
      result.held_period    <= trk.period_hold;
      result.scaled_period  <=
        per_prod[ectil_pkg::GAIN_SHIFT+ectil_pkg::PERIOD_W-1:ectil_pkg::GAIN_SHIFT];
      result.index_enable   <= trk.index_armed;
      result.rising_enable  <= trk.rising_armed;
      result.falling_enable <= trk.falling_armed;
      result.preset_command <= trk.preset_pending;
      result.preset_word    <= cfg.preset_value;
    end
  end

endmodule
